// ===== hw/rtl/min_max_range_histogram_core_assert.svh =====
// Assertion macros for the histogram core.
// Used only by the top level; no other dependencies.
`ifndef MIN_MAX_RANGE_HISTOGRAM_CORE_ASSERT_SVH
`define MIN_MAX_RANGE_HISTOGRAM_CORE_ASSERT_SVH
// An implication checked at every rising clock edge outside reset.
`define MMRH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// A next-cycle implication checked outside reset.
`define MMRH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== hw/rtl/mmrh_pkg.sv =====
// Shared constants for the histogram core.
// No dependencies.
package mmrh_pkg;
    localparam int MaxSamples  = 1024;
    localparam int MaxBins     = 63;
    localparam int SampleWidth = 32;
    localparam int AddrW       = $clog2(MaxSamples);
    localparam int CntW        = $clog2(MaxSamples + 1);
    localparam int BinW        = 6;
    localparam int SpanW       = SampleWidth + 1;
    localparam int NumW        = SpanW + BinW;
    localparam int PerBin      = 100;
    localparam logic [7:0] DefaultScale = 8'd52;
    localparam logic CfgBins  = 1'b0;
    localparam logic CfgScale = 1'b1;
endpackage

// ===== hw/rtl/mmrh_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module mmrh_ram #(
    parameter int Width = 32,
    parameter int Depth = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== hw/rtl/mmrh_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
// Uses mmrh_pkg for widths.
module mmrh_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [mmrh_pkg::NumW-1:0]      i_num,
    input  logic [mmrh_pkg::SpanW-1:0]     i_den,
    output logic                           o_done,
    output logic [mmrh_pkg::NumW-1:0]      o_quot
);
    localparam int StepW = $clog2(mmrh_pkg::NumW + 1);
    logic [mmrh_pkg::NumW-1:0]  r_q;
    logic [mmrh_pkg::SpanW:0]   r_rem;
    logic [mmrh_pkg::SpanW-1:0] r_den;
    logic [StepW-1:0]           r_step;
    logic                       r_busy;
    logic [mmrh_pkg::SpanW:0]   w_sh;
    logic                       w_ge;

    assign w_sh = {r_rem[mmrh_pkg::SpanW-1:0], r_q[mmrh_pkg::NumW-1]};
    assign w_ge = w_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_q    <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
                r_step <= StepW'(mmrh_pkg::NumW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= w_ge ? w_sh - {1'b0, r_den} : w_sh;
                r_q    <= {r_q[mmrh_pkg::NumW-2:0], w_ge};
                r_step <= r_step - 1'b1;
                if (r_step == StepW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_quot = r_q;
endmodule

// ===== hw/rtl/mmrh_bardiv.sv =====
// Serial divider for bar length: scale*count/peak, one bit per cycle.
// Uses mmrh_pkg for widths.
module mmrh_bardiv (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [18:0]                i_num,
    input  logic [mmrh_pkg::CntW-1:0]  i_den,
    output logic                       o_done,
    output logic [7:0]                 o_quot
);
    logic [18:0]               r_q;
    logic [mmrh_pkg::CntW:0]   r_rem;
    logic [mmrh_pkg::CntW-1:0] r_den;
    logic [4:0]                r_step;
    logic                      r_busy;
    logic [mmrh_pkg::CntW:0]   w_sh;
    logic                      w_ge;

    assign w_sh = {r_rem[mmrh_pkg::CntW-1:0], r_q[18]};
    assign w_ge = w_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_q <= i_num; r_rem <= '0; r_den <= i_den;
                r_step <= 5'd19; r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= w_ge ? w_sh - {1'b0, r_den} : w_sh;
                r_q    <= {r_q[17:0], w_ge};
                r_step <= r_step - 1'b1;
                if (r_step == 5'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    // Quotient never exceeds the scale, since count is at most peak.
    assign o_quot = (r_den == '0) ? 8'd0 : r_q[7:0];
endmodule

// ===== hw/rtl/min_max_range_histogram_core.sv =====
// Histogram core: a non-final sample is taken with busy low, so samples may follow
// back to back. The final sample keeps busy high while each held sample is read from the store,
// divided serially into its bin and counted, then while the bins are scanned for the peak and each
// bin's bar length is divided serially. Results leave one per bin; the receiver cannot stall.
// Reset is synchronous active low: registers to defaults, then a clearing pass
// over the bin counts with busy high.
`include "min_max_range_histogram_core_assert.svh"
module min_max_range_histogram_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    input  logic signed [31:0] i_sample,
    input  logic               i_final_sample,
    output logic               o_valid,
    output logic [5:0]         o_bin_index,
    output logic [10:0]        o_bin_count,
    output logic [7:0]         o_bar_length,
    output logic signed [31:0] o_range_low,
    output logic signed [31:0] o_range_high,
    output logic [5:0]         o_peak_bin,
    output logic               o_last_bin
);
    localparam int AW = mmrh_pkg::AddrW;
    localparam int CW = mmrh_pkg::CntW;
    localparam int SW = mmrh_pkg::SpanW;
    localparam int NW = mmrh_pkg::NumW;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_SETUP, S_RD, S_RDW, S_DIV, S_INC, S_PKRD, S_PKCMP,
        S_BRD, S_BAR, S_BARW, S_DONE
    } t_state;

    t_state r_state;
    logic [5:0]  r_bins_cfg;
    logic [7:0]  r_scale;
    logic [CW-1:0] r_held;
    logic signed [31:0] r_min, r_max, r_hi;
    logic [SW-1:0] r_span;
    logic [5:0]  r_nb;
    logic [CW-1:0] r_idx;
    logic [5:0]  r_j;
    logic [5:0]  r_bin;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_peak;
    logic [5:0]  r_peak_at;
    logic [CW-1:0] r_q100;

    logic          w_we;
    logic [AW-1:0] w_addr;
    logic signed [31:0] w_rd;
    logic          w_div_start, w_div_done, w_bar_start, w_bar_done;
    logic [NW-1:0] w_num, w_quot;
    logic [SW-1:0] w_d;
    logic [7:0]    w_bar;
    logic [5:0]    w_bin;
    logic [CW-1:0] w_nb_auto;
    logic          w_cnt_we;
    logic [5:0]    w_cnt_addr;
    logic [CW-1:0] w_cnt_wdata, w_cnt_rd;

    assign busy = (r_state != S_IDLE);
    assign w_we = (r_state == S_IDLE) && start && (r_held < CW'(mmrh_pkg::MaxSamples));
    assign w_addr = (r_state == S_IDLE) ? r_held[AW-1:0] : r_idx[AW-1:0];

    mmrh_ram #(.Width(32), .Depth(mmrh_pkg::MaxSamples)) u_store (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr), .i_wdata(i_sample), .o_rdata(w_rd)
    );

    // Bin counts live in a RAM: cleared after reset by a pass, and each bin is
    // zeroed again as it is read out for its result.
    always_comb begin
        w_cnt_we    = 1'b0;
        w_cnt_addr  = r_j;
        w_cnt_wdata = '0;
        unique case (r_state)
            S_CLR, S_BAR: w_cnt_we = 1'b1;
            S_DIV: w_cnt_addr = w_bin;
            S_INC: begin
                w_cnt_we    = 1'b1;
                w_cnt_addr  = r_bin;
                w_cnt_wdata = w_cnt_rd + CW'(1);
            end
            default: ;
        endcase
    end

    mmrh_ram #(.Width(CW), .Depth(mmrh_pkg::MaxBins + 1)) u_counts (
        .i_clk(i_clk), .i_we(w_cnt_we), .i_addr(w_cnt_addr), .i_wdata(w_cnt_wdata),
        .o_rdata(w_cnt_rd)
    );

    assign w_d   = SW'({w_rd[31], w_rd}) - SW'({r_min[31], r_min});
    assign w_num = NW'(w_d) * NW'(r_nb);
    assign w_div_start = (r_state == S_RDW);
    mmrh_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start), .i_num(w_num),
        .i_den(r_span), .o_done(w_div_done), .o_quot(w_quot)
    );
    assign w_bin = (w_quot > NW'(r_nb)) ? r_nb : w_quot[5:0];

    assign w_bar_start = (r_state == S_BAR);
    mmrh_bardiv u_bar (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_bar_start),
        .i_num(19'(r_scale) * 19'(w_cnt_rd)), .i_den(r_peak),
        .o_done(w_bar_done), .o_quot(w_bar)
    );

    // Held count over 100 is tracked with a modulo-100 counter while samples arrive.
    logic [6:0] r_mod100;
    assign w_nb_auto = (r_q100 == '0) ? CW'(1) :
                       (r_q100 > CW'(mmrh_pkg::MaxBins)) ? CW'(mmrh_pkg::MaxBins) : r_q100;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_j <= '0;
            r_bins_cfg <= '0;
            r_scale <= mmrh_pkg::DefaultScale;
            r_held <= '0;
            r_min <= '0;
            r_max <= '0;
            r_q100 <= '0;
            r_mod100 <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_index == mmrh_pkg::CfgBins) r_bins_cfg <= i_cfg_data[5:0];
                else r_scale <= i_cfg_data;
            end
            unique case (r_state)
                S_CLR: begin
                    r_j <= r_j + 1'b1;
                    if (r_j == 6'(mmrh_pkg::MaxBins)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (start) begin
                        if (w_we) begin
                            r_held <= r_held + 1'b1;
                            if (r_mod100 == 7'd99) begin
                                r_mod100 <= '0;
                                r_q100 <= r_q100 + 1'b1;
                            end else begin
                                r_mod100 <= r_mod100 + 1'b1;
                            end
                            if (r_held == '0) begin
                                r_min <= i_sample; r_max <= i_sample;
                            end else begin
                                if (i_sample < r_min) r_min <= i_sample;
                                if (i_sample > r_max) r_max <= i_sample;
                            end
                        end
                        if (i_final_sample) r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_nb <= (r_bins_cfg == '0) ? w_nb_auto[5:0] : r_bins_cfg;
                    if (r_max == r_min) begin
                        r_span <= SW'(1);
                        r_hi <= (r_max == 32'sh7FFFFFFF) ? r_max : r_max + 32'sd1;
                    end else begin
                        r_span <= SW'({r_max[31], r_max}) - SW'({r_min[31], r_min});
                        r_hi <= r_max;
                    end
                    r_idx <= '0;
                    r_state <= S_RD;
                end
                S_RD: begin
                    if (r_idx == r_held) begin
                        r_j <= '0; r_peak <= '0; r_peak_at <= '0;
                        r_state <= S_PKRD;
                    end else begin
                        r_state <= S_RDW;
                    end
                end
                S_RDW: r_state <= S_DIV;
                S_DIV: if (w_div_done) begin
                    r_bin <= w_bin;
                    r_state <= S_INC;
                end
                S_INC: begin
                    r_idx <= r_idx + 1'b1;
                    r_state <= S_RD;
                end
                S_PKRD: r_state <= S_PKCMP;
                S_PKCMP: begin
                    if (w_cnt_rd > r_peak) begin
                        r_peak <= w_cnt_rd; r_peak_at <= r_j;
                    end
                    if (r_j == r_nb) begin
                        r_j <= '0; r_state <= S_BRD;
                    end else begin
                        r_j <= r_j + 1'b1; r_state <= S_PKRD;
                    end
                end
                S_BRD: r_state <= S_BAR;
                S_BAR: begin
                    r_cnt <= w_cnt_rd;
                    r_state <= S_BARW;
                end
                S_BARW: if (w_bar_done) begin
                    o_valid <= 1'b1;
                    o_bin_index <= r_j;
                    o_bin_count <= r_cnt;
                    o_bar_length <= w_bar;
                    o_range_low <= r_min;
                    o_range_high <= r_hi;
                    o_peak_bin <= r_peak_at;
                    o_last_bin <= (r_j == r_nb);
                    if (r_j == r_nb) r_state <= S_DONE;
                    else begin
                        r_j <= r_j + 1'b1; r_state <= S_BRD;
                    end
                end
                S_DONE: begin
                    r_held <= '0; r_q100 <= '0; r_mod100 <= '0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `MMRH_ASSERT_IMPL(a_valid_busy, i_clk, i_rst_n, o_valid, busy)
    `MMRH_ASSERT_IMPL(a_last_ok, i_clk, i_rst_n, o_valid && o_last_bin, o_bin_index == r_nb)
    `MMRH_ASSERT_NEXT(a_held_bound, i_clk, i_rst_n, 1'b1,
        r_held <= CW'(mmrh_pkg::MaxSamples))
endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the min/max range histogram core.
// Depends on mmrh_pkg and min_max_range_histogram_core; predicts every bin result.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [5:0]         bin_index;
        logic [10:0]        bin_count;
        logic [7:0]         bar_length;
        logic signed [31:0] range_low;
        logic signed [31:0] range_high;
        logic [5:0]         peak_bin;
        logic               last_bin;
    } t_bin_result;

    localparam int WatchdogLimit = 200000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_index = mmrh_pkg::CfgBins;
    logic [7:0]         i_cfg_data = '0;
    logic signed [31:0] i_sample = '0;
    logic               i_final_sample = 1'b0;
    logic               o_valid;
    logic [5:0]         o_bin_index;
    logic [10:0]        o_bin_count;
    logic [7:0]         o_bar_length;
    logic signed [31:0] o_range_low;
    logic signed [31:0] o_range_high;
    logic [5:0]         o_peak_bin;
    logic               o_last_bin;

    min_max_range_histogram_core u_top (.*);

    always #2 i_clk = ~i_clk;

    // Predictor state.
    logic [5:0]         bins_reg = 6'd0;
    logic [7:0]         scale_reg = mmrh_pkg::DefaultScale;
    logic signed [31:0] run_samples[$];
    logic signed [31:0] run_lo = '0;
    logic signed [31:0] run_hi = '0;
    t_bin_result        expected_bins[$];

    int  mismatches = 0;
    int  items_sent = 0;
    bit  allow_idle = 1'b1;
    int  quiet_cycles = 0;

    // Builds the per-bin results of a finished run.
    task automatic close_run();
        int nb, peak, peak_at;
        int counts[64];
        longint unsigned span, d, b;
        logic signed [31:0] hi_out;
        t_bin_result r;
        nb = bins_reg;
        if (nb == 0) begin
            nb = run_samples.size() / mmrh_pkg::PerBin;
            if (nb < 1) nb = 1;
        end
        if (nb > mmrh_pkg::MaxBins) nb = mmrh_pkg::MaxBins;
        span = longint'(run_hi) - longint'(run_lo);
        hi_out = run_hi;
        if (span == 0) begin
            span = 1;
            if (run_hi != 32'sh7FFF_FFFF) hi_out = run_hi + 32'sd1;
        end
        foreach (counts[j]) counts[j] = 0;
        foreach (run_samples[i]) begin
            d = longint'(run_samples[i]) - longint'(run_lo);
            b = (longint'(nb) * d) / span;
            if (b > nb) b = nb;
            counts[b]++;
        end
        peak = 0;
        peak_at = 0;
        for (int j = 0; j <= nb; j++) begin
            if (counts[j] > peak) begin
                peak = counts[j];
                peak_at = j;
            end
        end
        for (int j = 0; j <= nb; j++) begin
            r.bin_index  = 6'(j);
            r.bin_count  = 11'(counts[j]);
            r.bar_length = (peak == 0) ? 8'd0 : 8'((int'(scale_reg) * counts[j]) / peak);
            r.range_low  = run_lo;
            r.range_high = hi_out;
            r.peak_bin   = 6'(peak_at);
            r.last_bin   = (j == nb);
            expected_bins.push_back(r);
        end
        run_samples.delete();
    endtask

    task automatic send_sample(input logic signed [31:0] value, input logic fin);
        if (allow_idle && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_sample <= value;
        i_final_sample <= fin;
        // Busy is looked at mid-cycle, so the next rising edge is the accepting one.
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        items_sent++;
        // Samples beyond the store size are dropped, but a final one still ends the run.
        if (run_samples.size() < mmrh_pkg::MaxSamples) begin
            if (run_samples.size() == 0) begin
                run_lo = value;
                run_hi = value;
            end else begin
                if (value < run_lo) run_lo = value;
                if (value > run_hi) run_hi = value;
            end
            run_samples.push_back(value);
        end
        if (fin) close_run();
    endtask

    task automatic drain();
        start <= 1'b0;
        wait (expected_bins.size() == 0);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic index, input logic [7:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (index == mmrh_pkg::CfgBins) bins_reg = value[5:0];
        else scale_reg = value;
    endtask

    task automatic send_run(input int length, input logic signed [31:0] base,
                            input int unsigned spread);
        logic signed [31:0] v;
        for (int k = 0; k < length; k++) begin
            if (spread == 0) v = $urandom();
            else v = base + $signed($urandom_range(0, spread));
            send_sample(v, k == length - 1);
        end
    endtask

    task automatic test_extremes();
        write_reg(mmrh_pkg::CfgBins, 8'd63);
        write_reg(mmrh_pkg::CfgScale, 8'd255);
        send_sample(32'sh8000_0000, 1'b0);
        send_sample(32'sh7FFF_FFFF, 1'b0);
        send_sample(32'sh0000_0000, 1'b0);
        send_sample(32'shFFFF_FFFF, 1'b1);
        drain();
        // A single largest sample: zero range and saturated upper bound.
        send_sample(32'sh7FFF_FFFF, 1'b1);
        send_sample(32'sh8000_0000, 1'b1);
        send_sample(-32'sd5, 1'b0);
        send_sample(-32'sd5, 1'b1);
        drain();
    endtask

    task automatic test_scale_and_bins();
        write_reg(mmrh_pkg::CfgScale, 8'd0);
        write_reg(mmrh_pkg::CfgBins, 8'd1);
        send_run(6, -32'sd3, 6);
        drain();
        // Upper data bits are beyond the bins register and are dropped.
        write_reg(mmrh_pkg::CfgBins, 8'hFF);
        write_reg(mmrh_pkg::CfgScale, 8'd1);
        send_run(8, 32'sd100, 40);
        drain();
    endtask

    task automatic test_derived_bins();
        write_reg(mmrh_pkg::CfgBins, 8'd0);
        write_reg(mmrh_pkg::CfgScale, mmrh_pkg::DefaultScale);
        send_run(5, 32'sd0, 10);
        send_run(250, -32'sd1000, 2000);
        drain();
    endtask

    task automatic test_random_runs();
        int target;
        target = items_sent + 180;
        while (items_sent < target) begin
            if (target - items_sent < 100) allow_idle = 1'b0;
            if ($urandom_range(0, 3) == 0) begin
                drain();
                write_reg(mmrh_pkg::CfgBins,
                          ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(1, 63)));
                write_reg(mmrh_pkg::CfgScale, 8'($urandom_range(0, 255)));
            end
            case ($urandom_range(0, 4))
                0: send_run($urandom_range(1, 20), 32'sh0, 0);
                1: send_run($urandom_range(1, 3), $urandom(), 2);
                default: send_run($urandom_range(2, 20), $urandom(), $urandom_range(1, 5000));
            endcase
        end
        drain();
    endtask

    always @(posedge i_clk) begin
        t_bin_result got, want;
        if (o_valid) begin
            got = '{o_bin_index, o_bin_count, o_bar_length, o_range_low, o_range_high,
                    o_peak_bin, o_last_bin};
            if (expected_bins.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected bin result %p", got);
            end else begin
                want = expected_bins.pop_front();
                if (got.bin_index !== want.bin_index || got.bin_count !== want.bin_count ||
                    got.bar_length !== want.bar_length || got.range_low !== want.range_low ||
                    got.range_high !== want.range_high || got.peak_bin !== want.peak_bin ||
                    got.last_bin !== want.last_bin) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("bin mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    // Counts cycles with no transaction on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || o_valid || (start && !busy)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_scale_and_bins();
        test_derived_bins();
        test_random_runs();
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && expected_bins.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
